[rtl/cld_pkg.sv]
// ----------------------------------------------------------------------------
// cld_pkg
// Shared constants for the content-length deframer: character codes, the
// header key text and the result status codes.
// ----------------------------------------------------------------------------
package cld_pkg;

	// Number of bytes in the "Content-Length:" key.
	localparam logic [3:0] PREFIX_LEN = 4'd15;

	// Character codes used by the line parser.
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// Result status codes.
	localparam logic [1:0] ST_BODY     = 2'd0;
	localparam logic [1:0] ST_CLOSED   = 2'd1;
	localparam logic [1:0] ST_BAD_LEN  = 2'd2;
	localparam logic [1:0] ST_TOO_LONG = 2'd3;

	// Message phase codes; the spare code behaves as the header phase.
	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_CR     = 2'd1;
	localparam logic [1:0] PH_BODY   = 2'd2;

	// Number parser phase codes.
	localparam logic [1:0] NP_SKIP   = 2'd0;
	localparam logic [1:0] NP_SIGN   = 2'd1;
	localparam logic [1:0] NP_DIGITS = 2'd2;
	localparam logic [1:0] NP_DONE   = 2'd3;

	// Byte of the header key at a given position.
	function automatic logic [7:0] key_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = "C";
			4'd1:    c = "o";
			4'd2:    c = "n";
			4'd3:    c = "t";
			4'd4:    c = "e";
			4'd5:    c = "n";
			4'd6:    c = "t";
			4'd7:    c = "-";
			4'd8:    c = "L";
			4'd9:    c = "e";
			4'd10:   c = "n";
			4'd11:   c = "g";
			4'd12:   c = "t";
			4'd13:   c = "h";
			4'd14:   c = ":";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

[rtl/content_length_deframer_core.sv]
// ----------------------------------------------------------------------------
// content_length_deframer_core
// A request accepted into the input stage register has its result driven
// from the result register. Throughput: one input byte per cycle, set by the
// single parse stage, while no result waits on a stalled output.
// Reset: asynchronous, clears to the start of a header with no length seen
// and max_body_length at 1048576 (truncated to LENGTH_WIDTH bits).
// Recovers message bodies from a byte stream of CR LF terminated header
// lines, an empty line and a body whose size a Content-Length line gives.
// ----------------------------------------------------------------------------
module content_length_deframer_core #(
	parameter int LENGTH_WIDTH = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              data_byte,
	input  logic                    stream_closed,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [7:0]              body_byte,
	output logic                    last_of_body,
	output logic [1:0]              status,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [LENGTH_WIDTH-1:0] max_body_length
);
	import cld_pkg::*;

	localparam int LW = LENGTH_WIDTH;
	localparam logic [LW-1:0] MAX_RESET = LW'(64'd1048576);

	// Per-line parser state.
	typedef struct packed {
		logic [3:0]  pos;
		logic        pm;
		logic [1:0]  np;
		logic        neg;
		logic [LW:0] val;
	} line_t;

	localparam line_t LINE_CLEAR = '{pos: 4'd0, pm: 1'b1, np: NP_SKIP, neg: 1'b0,
		val: '0};

	// Feeds one byte into the current header line.
	function automatic line_t add_to_line(input line_t ls, input logic [7:0] b);
		line_t         r;
		logic          is_digit;
		logic          is_ws;
		logic [LW+4:0] prod;
		r = ls;
		is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
		is_ws = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
		prod = ({4'b0, ls.val} << 3) + ({4'b0, ls.val} << 1)
			+ (LW+5)'(b[3:0]);
		if (ls.pos < PREFIX_LEN) begin
			if (b != key_char(ls.pos))
				r.pm = 1'b0;
			r.pos = 4'(ls.pos + 4'd1);
		end else if (ls.pm) begin
			case (ls.np)
				NP_SKIP: begin
					if (is_ws) begin
						r.np = NP_SKIP;
					end else if (b == CHAR_PLUS) begin
						r.np = NP_SIGN;
					end else if (b == CHAR_MINUS) begin
						r.neg = 1'b1;
						r.np = NP_SIGN;
					end else if (is_digit) begin
						r.val = (prod[LW+4:LW+1] != 4'd0) ? '1 : prod[LW:0];
						r.np = NP_DIGITS;
					end else begin
						r.np = NP_DONE;
					end
				end
				NP_SIGN, NP_DIGITS: begin
					if (is_digit) begin
						r.val = (prod[LW+4:LW+1] != 4'd0) ? '1 : prod[LW:0];
						r.np = NP_DIGITS;
					end else begin
						r.np = NP_DONE;
					end
				end
				default: r.np = NP_DONE;
			endcase
		end
		return r;
	endfunction

	// Input stage register.
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       closed_s1;

	// Parser and message state.
	logic [1:0]    phase_q;
	line_t         line_q;
	logic          decl_neg_q;
	logic [LW:0]   decl_mag_q;
	logic [LW-1:0] body_rem_q;
	logic [LW-1:0] max_len_q;

	// Result register.
	logic       out_valid_q;
	logic [7:0] body_byte_q;
	logic       last_q;
	logic [1:0] status_q;

	// Next-state values.
	logic [1:0]    phase_d;
	line_t         line_d;
	logic          decl_neg_d;
	logic [LW:0]   decl_mag_d;
	logic [LW-1:0] body_rem_d;
	logic          res_has;
	logic [7:0]    res_byte;
	logic          res_last;
	logic [1:0]    res_status;
	logic          s1_adv;

	// Parse step for the byte held in the input stage.
	always_comb begin
		phase_d    = phase_q;
		line_d     = line_q;
		decl_neg_d = decl_neg_q;
		decl_mag_d = decl_mag_q;
		body_rem_d = body_rem_q;
		res_has    = 1'b0;
		res_byte   = 8'h00;
		res_last   = 1'b0;
		res_status = ST_BODY;
		if (closed_s1) begin
			res_has    = 1'b1;
			res_status = ST_CLOSED;
			phase_d    = PH_HEADER;
			line_d     = LINE_CLEAR;
			decl_neg_d = 1'b1;
			decl_mag_d = (LW+1)'(1);
			body_rem_d = '0;
		end else if (phase_q == PH_BODY) begin
			res_has  = 1'b1;
			res_byte = data_s1;
			res_last = (body_rem_q <= LW'(1));
			if (res_last) begin
				phase_d    = PH_HEADER;
				line_d     = LINE_CLEAR;
				decl_neg_d = 1'b1;
				decl_mag_d = (LW+1)'(1);
				body_rem_d = '0;
			end else begin
				body_rem_d = body_rem_q - LW'(1);
			end
		end else if (phase_q == PH_CR) begin
			phase_d = PH_HEADER;
			if (data_s1 == CHAR_LF) begin
				if (line_q.pos == 4'd0) begin
					// Empty line: check the declared length, then start the body or report an error.
					if (decl_neg_q || (decl_mag_q == '0) ||
						(decl_mag_q > {1'b0, max_len_q})) begin
						res_has    = 1'b1;
						res_status = (decl_neg_q || (decl_mag_q == '0)) ?
							ST_BAD_LEN : ST_TOO_LONG;
						line_d     = LINE_CLEAR;
						decl_neg_d = 1'b1;
						decl_mag_d = (LW+1)'(1);
						body_rem_d = '0;
					end else begin
						line_d     = LINE_CLEAR;
						body_rem_d = decl_mag_q[LW-1:0];
						phase_d    = PH_BODY;
					end
				end else begin
					// End of a header line: a key line updates the length.
					if ((line_q.pos == PREFIX_LEN) && line_q.pm) begin
						decl_neg_d = line_q.neg;
						decl_mag_d = line_q.val;
					end
					line_d = LINE_CLEAR;
				end
			end else begin
				line_d = add_to_line(add_to_line(line_q, CHAR_CR), data_s1);
			end
		end else begin
			phase_d = PH_HEADER;
			if (data_s1 == CHAR_CR)
				phase_d = PH_CR;
			else
				line_d = add_to_line(line_q, data_s1);
		end
	end

	// The stage moves on unless it holds a result and the output is full.
	assign s1_adv   = valid_s1 && (!res_has || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_adv;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1   <= data_byte;
			closed_s1 <= stream_closed;
		end
	end

	// Parser state and configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			line_q     <= LINE_CLEAR;
			decl_neg_q <= 1'b1;
			decl_mag_q <= (LW+1)'(1);
			body_rem_q <= '0;
			max_len_q  <= MAX_RESET;
		end else begin
			if (s1_adv) begin
				phase_q    <= phase_d;
				line_q     <= line_d;
				decl_neg_q <= decl_neg_d;
				decl_mag_q <= decl_mag_d;
				body_rem_q <= body_rem_d;
			end
			if (cfg_valid)
				max_len_q <= max_body_length;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && res_has) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && res_has) begin
			body_byte_q <= res_byte;
			last_q      <= res_last;
			status_q    <= res_status;
		end
	end

	assign out_valid    = out_valid_q;
	assign body_byte    = body_byte_q;
	assign last_of_body = last_q;
	assign status       = status_q;
	assign cfg_ready    = 1'b1;

`ifndef SYNTH
	// Only body results may carry the end-of-body mark.
	a_last_is_body: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_body |-> status == ST_BODY)
		else $error("last_of_body set on an error result");

	// Error results carry a zero byte and no mark.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_BODY |-> body_byte == 8'h00 && !last_of_body)
		else $error("error result with nonzero payload");

	// The input stage stalls only behind a full, unaccepted output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |-> out_valid_q && !out_ready)
		else $error("input stage stalled without output back-pressure");

	// While in the body there is always at least one byte left.
	a_body_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> body_rem_q != '0)
		else $error("body phase with zero bytes remaining");
`endif

endmodule

[dv/content_length_deframer_core_tb.sv]
// ----------------------------------------------------------------------------
// content_length_deframer_core_tb
// Self-checking bench for the content-length deframer. A short table of
// directed byte strings covers closed streams, missing and bad lengths,
// saturating numbers, whitespace rules and CR handling. It is followed by
// random messages under several max_body_length settings. Each accepted
// request runs through a local parser that predicts the body bytes and
// error results, and the monitor checks every returned result in order.
// ----------------------------------------------------------------------------
module content_length_deframer_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import cld_pkg::*;

	localparam int     LENGTH_WIDTH  = 24;
	localparam longint ACC_MAX       = (longint'(1) << (LENGTH_WIDTH + 1)) - 1;
	localparam int     RESET_LIMIT   = 1048576;
	localparam int     PHASE_ITEMS   = 180;
	localparam int     SETTLE_CYCLES = 6;
	localparam int     DRAIN_CYCLES  = 8;
	localparam int     HOLD_CYCLES   = 300;
	localparam int     CYCLE_LIMIT   = 400000;
	localparam logic [7:0] CHAR_VT   = 8'h0B;
	localparam logic [7:0] CHAR_FF   = 8'h0C;

	// One result of the deframer, as seen on the output port.
	typedef struct packed {
		logic [7:0] body;
		logic       last;
		logic [1:0] st;
	} frame_out_t;

	// One input request: a stream byte or a closed-stream report.
	typedef struct packed {
		logic [7:0] d;
		logic       c;
	} stream_req_t;

	// Directed stimulus row: text, optional raw tail byte, optional close.
	typedef struct {
		string      txt;
		bit         has_tail;
		logic [7:0] tail;
		bit         close;
		bit         typed;
		logic [1:0] st;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'h00;
	logic stream_closed = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] body_byte;
	logic last_of_body;
	logic [1:0] status;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [LENGTH_WIDTH-1:0] max_body_length = LENGTH_WIDTH'(RESET_LIMIT);

	content_length_deframer_core #(
		.LENGTH_WIDTH(LENGTH_WIDTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.stream_closed(stream_closed),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.body_byte(body_byte),
		.last_of_body(last_of_body),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.max_body_length(max_body_length)
	);

	// Clock: 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Local copy of the parser state and the length limit.
	string       key_text = "Content-Length:";
	logic [1:0]  msg_phase;
	int          line_len;
	bit          key_seen;
	logic [1:0]  scan_phase;
	bit          scan_neg;
	longint      scan_acc;
	longint      length_decl;
	longint      body_left;
	longint      limit_setting;

	frame_out_t  awaited_results[$];
	stream_req_t byte_plan[$];
	stim_row_t   directed_rows[0:10];
	longint      limit_plan[0:5];

	int          mismatches;
	int          items_sent;
	int          results_checked;
	int          bodies_done;
	int          closed_seen;
	int          bad_len_seen;
	int          too_long_seen;
	int          settings_written;
	int          burst_left;
	int          cycle_count;
	int          rx_left;
	bit          rx_on;
	bit          hold_off = 1'b0;
	frame_out_t  want;

	// ------------------------------------------------------------------
	// Parser prediction
	// ------------------------------------------------------------------

	function automatic void clear_line_state();
		line_len = 0;
		key_seen = 1'b1;
		scan_phase = NP_SKIP;
		scan_neg = 1'b0;
		scan_acc = 0;
	endfunction

	function automatic void restart_message();
		msg_phase = PH_HEADER;
		clear_line_state();
		length_decl = -1;
		body_left = 0;
	endfunction

	function automatic void push_digit(input logic [7:0] b);
		longint v;
		v = scan_acc * 10 + longint'(b - CHAR_ZERO);
		scan_acc = (v > ACC_MAX) ? ACC_MAX : v;
		scan_phase = NP_DIGITS;
	endfunction

	// atoi-style reading of the text after the key.
	function automatic void scan_length_char(input logic [7:0] b);
		bit is_digit;
		is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
		if (scan_phase == NP_SKIP) begin
			if (b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR))
				return;
			if (b == CHAR_PLUS) begin
				scan_phase = NP_SIGN;
				return;
			end
			if (b == CHAR_MINUS) begin
				scan_neg = 1'b1;
				scan_phase = NP_SIGN;
				return;
			end
			if (is_digit) begin
				push_digit(b);
				return;
			end
			scan_phase = NP_DONE;
		end else if (scan_phase != NP_DONE) begin
			if (is_digit)
				push_digit(b);
			else
				scan_phase = NP_DONE;
		end
	endfunction

	function automatic void take_line_byte(input logic [7:0] b);
		logic [7:0] k;
		if (line_len < PREFIX_LEN) begin
			k = key_text[line_len];
			if (b != k)
				key_seen = 1'b0;
			line_len++;
		end else if (key_seen) begin
			scan_length_char(b);
		end
	endfunction

	// End of a header line; the empty line decides between body and error.
	function automatic bit finish_line(output frame_out_t r);
		r = '0;
		if (line_len == 0) begin
			if (length_decl <= 0) begin
				restart_message();
				r.st = ST_BAD_LEN;
				return 1'b1;
			end
			if (length_decl > limit_setting) begin
				restart_message();
				r.st = ST_TOO_LONG;
				return 1'b1;
			end
			clear_line_state();
			body_left = length_decl;
			msg_phase = PH_BODY;
			return 1'b0;
		end
		if (line_len >= PREFIX_LEN && key_seen)
			length_decl = scan_neg ? -scan_acc : scan_acc;
		clear_line_state();
		return 1'b0;
	endfunction

	// Advances the parser by one request; returns 1 when a result is due.
	function automatic bit deframe_byte(input logic [7:0] b, input logic c,
			output frame_out_t r);
		r = '0;
		if (c) begin
			restart_message();
			r.st = ST_CLOSED;
			return 1'b1;
		end
		if (msg_phase == PH_BODY) begin
			r.body = b;
			r.st = ST_BODY;
			r.last = (body_left <= 1);
			if (r.last)
				restart_message();
			else
				body_left--;
			return 1'b1;
		end
		if (msg_phase == PH_CR) begin
			msg_phase = PH_HEADER;
			if (b == CHAR_LF)
				return finish_line(r);
			take_line_byte(CHAR_CR);
			take_line_byte(b);
			return 1'b0;
		end
		msg_phase = PH_HEADER;
		if (b == CHAR_CR)
			msg_phase = PH_CR;
		else
			take_line_byte(b);
		return 1'b0;
	endfunction

	// ------------------------------------------------------------------
	// Random message construction
	// ------------------------------------------------------------------

	function automatic void plan_byte(input logic [7:0] b);
		byte_plan.push_back('{d: b, c: 1'b0});
	endfunction

	function automatic void plan_close();
		byte_plan.push_back('{d: 8'($urandom_range(0, 255)), c: 1'b1});
	endfunction

	function automatic void plan_text(input string s);
		for (int i = 0; i < s.len(); i++)
			plan_byte(s[i]);
	endfunction

	function automatic void plan_eol();
		plan_byte(CHAR_CR);
		plan_byte(CHAR_LF);
	endfunction

	// Arbitrary line content; a CR is always followed by something but LF.
	function automatic void plan_junk(input int n);
		logic [7:0] b;
		repeat (n) begin
			b = 8'($urandom_range(0, 255));
			if (b == CHAR_CR) begin
				plan_byte(CHAR_CR);
				b = 8'($urandom_range(0, 255));
				if (b == CHAR_LF)
					b = CHAR_SPACE;
			end
			plan_byte(b);
		end
	endfunction

	// A header line that never sets the length.
	function automatic void plan_header_line();
		int k;
		logic [7:0] c;
		case ($urandom_range(0, 2))
			0: plan_junk($urandom_range(1, 16));
			1: begin
				// Key with one byte off by one, then a number.
				k = $urandom_range(0, 14);
				for (int i = 0; i < 15; i++) begin
					c = key_text[i];
					plan_byte((i == k) ? (c ^ 8'h01) : c);
				end
				plan_text($sformatf(" %0d", $urandom_range(1, 20)));
			end
			default: plan_text(key_text.substr(0, $urandom_range(0, 13)));
		endcase
		plan_eol();
	endfunction

	// A length line with random whitespace, sign, leading zeros and tail.
	function automatic void plan_length_line(input longint value, input bit neg);
		plan_text(key_text);
		repeat ($urandom_range(0, 3)) begin
			case ($urandom_range(0, 5))
				0: plan_byte(CHAR_SPACE);
				1: plan_byte(CHAR_TAB);
				2: plan_byte(CHAR_LF);
				3: plan_byte(CHAR_VT);
				4: plan_byte(CHAR_FF);
				default: begin
					plan_byte(CHAR_CR);
					plan_byte(CHAR_SPACE);
				end
			endcase
		end
		if (neg)
			plan_byte(CHAR_MINUS);
		else if ($urandom_range(0, 3) == 0)
			plan_byte(CHAR_PLUS);
		repeat ($urandom_range(0, 2))
			plan_byte(CHAR_ZERO);
		plan_text($sformatf("%0d", value));
		if ($urandom_range(0, 3) == 0) begin
			plan_text(($urandom_range(0, 1) == 0) ? " x" : ";q=");
			plan_junk($urandom_range(0, 6));
		end
		plan_eol();
	endfunction

	// One message; mostly well formed, sometimes bad, cut short or noise.
	function automatic void plan_message();
		int start;
		int kind;
		int len;
		int cap;
		start = byte_plan.size();
		kind = $urandom_range(0, 99);
		len = 0;
		if (kind >= 96) begin
			plan_junk($urandom_range(1, 30));
			plan_close();
			return;
		end
		repeat ($urandom_range(0, 2))
			plan_header_line();
		if (kind < 68) begin
			if ($urandom_range(0, 4) == 0)
				plan_length_line($urandom_range(0, 500), 1'($urandom_range(0, 1)));
			cap = (limit_setting < 24) ? int'(limit_setting) : 24;
			len = $urandom_range(1, cap);
			plan_length_line(len, 1'b0);
		end else if (kind < 76) begin
			case ($urandom_range(0, 2))
				0: plan_length_line(0, 1'($urandom_range(0, 1)));
				1: begin
					plan_text(key_text);
					plan_eol();
				end
				default: begin
					plan_text(key_text);
					plan_text("+x");
					plan_eol();
				end
			endcase
		end else if (kind < 82) begin
			plan_length_line($urandom_range(1, 99999), 1'b1);
		end else if (kind >= 86) begin
			if ($urandom_range(0, 2) == 0)
				plan_length_line(64'd99999999999, 1'b0);
			else
				plan_length_line(limit_setting + $urandom_range(1, 1000), 1'b0);
		end
		if ($urandom_range(0, 2) == 0)
			plan_header_line();
		plan_eol();
		repeat (len)
			plan_byte(8'($urandom_range(0, 255)));
		// Now and then the transport closes partway through.
		if ($urandom_range(0, 24) == 0) begin
			repeat ($urandom_range(1, byte_plan.size() - start))
				void'(byte_plan.pop_back());
			plan_close();
		end
	endfunction

	// ------------------------------------------------------------------
	// Input and configuration drivers
	// ------------------------------------------------------------------

	// Offers one request in bursts with random gaps, then predicts it.
	task automatic drive_request(input logic [7:0] d, input logic c,
			input bit typed, input logic [1:0] typed_st);
		frame_out_t r;
		bit got;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 20);
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= d;
		stream_closed <= c;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		got = deframe_byte(d, c, r);
		if (typed) begin
			r = '{body: 8'h00, last: 1'b0, st: typed_st};
			got = 1'b1;
		end
		if (got)
			awaited_results.push_back(r);
	endtask

	// Waits until the block has nothing left in flight.
	task automatic settle_idle();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input longint v);
		cfg_valid <= 1'b1;
		max_body_length <= LENGTH_WIDTH'(v);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_setting = v;
		settings_written++;
	endtask

	// ------------------------------------------------------------------
	// Output side
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what, input int got, input int exp_v);
		$display("MISMATCH at cycle %0d, result %0d: %s got %0d, expected %0d",
			cycle_count, results_checked, what, got, exp_v);
		mismatches++;
	endtask

	// Receiver stalls in runs of its own, and holds off fully on request.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_on = !rx_on;
			if (rx_on)
				rx_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 20);
			else
				rx_left = $urandom_range(1, 8);
		end
		rx_left--;
		out_ready <= rx_on && !hold_off;
	end

	// One long hold-off while the sender keeps offering requests.
	initial begin
		wait (items_sent >= 500);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Compare each returned result with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("status of unawaited result", status, -1);
			end else begin
				want = awaited_results.pop_front();
				if (body_byte !== want.body)
					report_mismatch("body_byte", body_byte, want.body);
				if (last_of_body !== want.last)
					report_mismatch("last_of_body", last_of_body, want.last);
				if (status !== want.st)
					report_mismatch("status", status, want.st);
				case (want.st)
					ST_CLOSED:   closed_seen++;
					ST_BAD_LEN:  bad_len_seen++;
					ST_TOO_LONG: too_long_seen++;
					default:     if (want.last) bodies_done++;
				endcase
			end
			results_checked++;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycle_count, awaited_results.size());
			$display("content_length_deframer_core_tb NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		int n;
		int phase_items;

		directed_rows = '{
			'{"", 1'b0, 8'h00, 1'b1, 1'b1, ST_CLOSED},
			'{"\015\012", 1'b0, 8'h00, 1'b0, 1'b1, ST_BAD_LEN},
			'{"Content-Length: 0\015\012\015\012", 1'b0, 8'h00, 1'b0, 1'b1, ST_BAD_LEN},
			'{"Content-Length:\t-5\015\012\015\012", 1'b0, 8'h00, 1'b0, 1'b1, ST_BAD_LEN},
			'{"Content-Length: 99999999999\015\012\015\012", 1'b0, 8'h00, 1'b0, 1'b1,
				ST_TOO_LONG},
			'{"Content-Length: +3\015\012\015\012\377\015Z", 1'b0, 8'h00, 1'b0, 1'b0,
				ST_BODY},
			'{"Content-Length: 9\015\012Content-Length:\011\012\013\014\015 2\015x\015\012\015\012ab",
				1'b0, 8'h00, 1'b0, 1'b0, ST_BODY},
			'{"content-Length: 4\015\012\015\012", 1'b0, 8'h00, 1'b0, 1'b1, ST_BAD_LEN},
			'{"ab\015", 1'b0, 8'h00, 1'b1, 1'b1, ST_CLOSED},
			'{"Content-Length: 4\015\012\015\012ab", 1'b0, 8'h00, 1'b1, 1'b1, ST_CLOSED},
			'{"Content-Length: 1;x\015\012\015\012", 1'b1, 8'h00, 1'b0, 1'b0, ST_BODY}
		};
		limit_plan = '{1, 16777215, 0, RESET_LIMIT, 0, 24};
		limit_plan[2] = $urandom_range(2, 30);
		limit_plan[4] = $urandom_range(1000, 16777214);

		limit_setting = RESET_LIMIT;
		restart_message();

		// Hold reset, then release it.
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table under the reset limit.
		foreach (directed_rows[i]) begin
			n = directed_rows[i].txt.len();
			for (int j = 0; j < n; j++)
				drive_request(directed_rows[i].txt[j], 1'b0,
					directed_rows[i].typed && j == n - 1 && !directed_rows[i].has_tail
					&& !directed_rows[i].close, directed_rows[i].st);
			if (directed_rows[i].has_tail)
				drive_request(directed_rows[i].tail, 1'b0,
					directed_rows[i].typed && !directed_rows[i].close,
					directed_rows[i].st);
			if (directed_rows[i].close)
				drive_request(8'h00, 1'b1, directed_rows[i].typed, directed_rows[i].st);
		end

		// Random messages under each limit setting.
		foreach (limit_plan[p]) begin
			settle_idle();
			write_limit(limit_plan[p]);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				plan_message();
				while (byte_plan.size() != 0) begin
					drive_request(byte_plan[0].d, byte_plan[0].c, 1'b0, ST_BODY);
					void'(byte_plan.pop_front());
					phase_items++;
				end
			end
		end

		// Drain.
		in_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests over %0d limit settings; checked %0d results.",
			items_sent, settings_written, results_checked);
		$display("Bodies completed %0d, closed %0d, bad length %0d, too long %0d.",
			bodies_done, closed_seen, bad_len_seen, too_long_seen);
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("content_length_deframer_core_tb OK");
		else
			$display("content_length_deframer_core_tb NOT OK");
		$finish;
	end

endmodule
